@@ design/pair_pkg.sv @@
// ----------------------------------------------------------------------------
// pair_pkg
// Shared types and constants for the packed array insert/remove block.
// ----------------------------------------------------------------------------
package pair_pkg;

    localparam int WORD_W    = 32;
    localparam int POS_W     = 8;
    localparam int CNT_OUT_W = 9;

    // Operation selector carried on the input side.
    typedef enum logic [1:0] {
        OP_APPEND     = 2'd0,
        OP_REMOVE_VAL = 2'd1,
        OP_REMOVE_AT  = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    // Result status.
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_ZERO = 2'd1,
        IDX_POS  = 2'd2,
        IDX_INC  = 2'd3
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_POS  = 2'd0,
        RD_ZERO = 2'd1,
        RD_IDX1 = 2'd2,
        RD_IDX2 = 2'd3
    } rd_sel_t;

    typedef enum logic {
        WR_APPEND = 1'b0,
        WR_SHIFT  = 1'b1
    } wr_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    set_status;
        status_t status_code;
        idx_op_t idx_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    append;
        logic    drop;
        logic    grab_rdata;
        logic    load_out;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic pos_ok;
        logic count_zero;
        logic match;
        logic last1;
        logic last2;
    } stat_t;

endpackage

@@ design/pair_ram.sv @@
// ----------------------------------------------------------------------------
// pair_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pair_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/pair_ctrl.sv @@
// ----------------------------------------------------------------------------
// pair_ctrl
// Sequencer: decode, scan, shift-down and result handoff.
// ----------------------------------------------------------------------------
module pair_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output pair_pkg::cmd_t  cmd,
    input  pair_pkg::stat_t stat
);

    import pair_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_RDWAIT   = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_SHIFT_RD = 8'b0001_0000,
        S_SHIFT    = 8'b0010_0000,
        S_DROP     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_APPEND;
                            cmd.append = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    OP_REMOVE_VAL:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_MISS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                    OP_REMOVE_AT:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_MISS;
                            state_next      = S_DONE;
                        end
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.grab_rdata = 1'b1;
                state_next     = S_DONE;
            end
            S_SCAN:
            begin
                // data for idx is here; next address goes out speculatively
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX1;
                if (stat.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (stat.last1)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.last1)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // mem[idx] <= mem[idx+1], fetch idx+2
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX2;
                if (stat.last2)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/pair_dp.sv @@
// ----------------------------------------------------------------------------
// pair_dp
// Datapath: item registers, entry RAM, count/capacity and result register.
// ----------------------------------------------------------------------------
module pair_dp #(
    parameter int STORE_DEPTH    = 256,
    parameter int START_CAPACITY = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pair_pkg::op_t                        in_op,
    input  logic signed [pair_pkg::WORD_W-1:0]   in_value,
    input  logic [pair_pkg::POS_W-1:0]           in_pos,
    input  pair_pkg::cmd_t                       cmd,
    output pair_pkg::stat_t                      stat,
    output pair_pkg::status_t                    out_status,
    output logic signed [pair_pkg::WORD_W-1:0]   out_data,
    output logic [pair_pkg::CNT_OUT_W-1:0]       out_count,
    output logic [pair_pkg::CNT_OUT_W-1:0]       out_cap
);

    import pair_pkg::*;

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = $clog2(STORE_DEPTH + 1);
    localparam int MAXC = (STORE_DEPTH > START_CAPACITY) ? STORE_DEPTH : START_CAPACITY;
    localparam int CAPW = $clog2(MAXC + 1);
    localparam int PW   = AW + POS_W;

    op_t                status_dummy_op;
    op_t                op_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [POS_W-1:0]   pos_reg;
    status_t            status_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic [CW-1:0]      count_reg;
    logic [CAPW-1:0]    cap_reg;
    logic [CW-1:0]      idx_reg;

    logic [PW-1:0]      pos_wide;
    logic [PW-1:0]      count_pw;
    logic [CW:0]        idx1;
    logic [CW:0]        idx2;
    logic [CW:0]        count_x;
    logic [CW-1:0]      count_dec;
    logic [CAPW-1:0]    count_c;
    logic [CAPW-1:0]    count_dec_c;
    logic [CAPW:0]      cap_dbl;
    logic [CAPW:0]      depth_x;
    logic [CAPW-1:0]    cap_grow;
    logic [CW+CNT_OUT_W-1:0]   count_out_x;
    logic [CAPW+CNT_OUT_W-1:0] cap_out_x;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [WORD_W-1:0]  ram_rd_data;

    assign status_dummy_op = op_reg;

    assign pos_wide    = PW'(pos_reg);
    assign count_pw    = PW'(count_reg);
    assign idx1        = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx2        = {1'b0, idx_reg} + (CW+1)'(2);
    assign count_x     = {1'b0, count_reg};
    assign count_dec   = count_reg - CW'(1);
    assign count_c     = CAPW'(count_reg);
    assign count_dec_c = CAPW'(count_dec);
    assign cap_dbl     = {cap_reg, 1'b0};
    assign depth_x     = (CAPW+1)'(STORE_DEPTH);
    assign cap_grow    = (cap_dbl > depth_x) ? depth_x[CAPW-1:0] : cap_dbl[CAPW-1:0];
    assign count_out_x = (CW+CNT_OUT_W)'(count_reg);
    assign cap_out_x   = (CAPW+CNT_OUT_W)'(cap_reg);

    // status to the sequencer
    always_comb
    begin
        stat.op         = status_dummy_op;
        stat.full       = (count_reg == CW'(STORE_DEPTH));
        stat.pos_ok     = (pos_wide < count_pw);
        stat.count_zero = (count_reg == '0);
        stat.match      = (ram_rd_data == value_reg);
        stat.last1      = (idx1 == count_x);
        stat.last2      = (idx2 == count_x);
    end

    // RAM port steering
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_POS:  ram_rd_addr = pos_wide[AW-1:0];
            RD_ZERO: ram_rd_addr = '0;
            RD_IDX1: ram_rd_addr = idx1[AW-1:0];
            RD_IDX2: ram_rd_addr = idx2[AW-1:0];
        endcase
        unique case (cmd.wr_sel)
            WR_APPEND:
            begin
                ram_wr_addr = count_reg[AW-1:0];
                ram_wr_data = value_reg;
            end
            WR_SHIFT:
            begin
                ram_wr_addr = idx_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
            end
        endcase
    end

    assign ram_wr_en = cmd.wr_en;

    pair_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_op;
            value_reg  <= $unsigned(in_value);
            pos_reg    <= in_pos;
            status_reg <= ST_DONE;
            rdata_reg  <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.grab_rdata)
            begin
                rdata_reg <= ram_rd_data;
            end
        end

        unique case (cmd.idx_op)
            IDX_HOLD: idx_reg <= idx_reg;
            IDX_ZERO: idx_reg <= '0;
            IDX_POS:  idx_reg <= pos_wide[CW-1:0];
            IDX_INC:  idx_reg <= idx1[CW-1:0];
        endcase

        if (cmd.load_out)
        begin
            out_status <= status_reg;
            out_data   <= $signed(rdata_reg);
            out_count  <= count_out_x[CNT_OUT_W-1:0];
            out_cap    <= cap_out_x[CNT_OUT_W-1:0];
        end
    end

    // count and nominal capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAPW'(START_CAPACITY);
        end
        else if (cmd.append)
        begin
            count_reg <= count_reg + CW'(1);
            if (count_c >= cap_reg)
            begin
                cap_reg <= cap_grow;
            end
        end
        else if (cmd.drop)
        begin
            count_reg <= count_dec;
            if (count_dec_c < (cap_reg >> 2))
            begin
                cap_reg <= cap_reg >> 1;
            end
        end
    end

endmodule

@@ design/packed_array_insert_remove_top.sv @@
// ----------------------------------------------------------------------------
// packed_array_insert_remove_top
// Packed list of signed words with append, remove-by-value, remove-at-index
// and read, plus a nominal capacity that doubles and halves with use.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  ---------+-----+------------------------------------------+-----------
//  s_axis   | in  | value[31:0], position[39:32], pad to 48   | operation
//  m_axis   | out | read_data[31:0], entry_count[40:32],      | status
//           |     | nominal_capacity[49:41], pad to 56        |
//
//  Append and any miss found at decode finish straight from decode; a read
//  waits for the registered RAM data. Remove-by-value scans from index zero
//  until a match or the last entry, and on a match moves every later entry
//  down one place, as remove-at-index does from its position. The single
//  read port of the entry RAM sets the pace: one entry is scanned or moved
//  down per cycle.
//  Reset clears the count to zero and the capacity to START_CAPACITY; the
//  RAM is not cleared, and only entries below the count affect a result.
//  One item is in work at a time; a new transfer is taken while the last
//  result still waits in the output register. A stalled output holds the
//  sequencer in its final state until the result register frees up.
//
module packed_array_insert_remove_top #(
    parameter int STORE_DEPTH    = 256,
    parameter int START_CAPACITY = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value[31:0], position[39:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data[31:0], entry_count[40:32],
                                        // nominal_capacity[49:41], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    import pair_pkg::*;

    cmd_t                     cmd;
    stat_t                    stat;
    op_t                      in_op;
    logic signed [WORD_W-1:0] in_value;
    logic [POS_W-1:0]         in_pos;
    status_t                  out_status;
    logic signed [WORD_W-1:0] out_data;
    logic [CNT_OUT_W-1:0]     out_count;
    logic [CNT_OUT_W-1:0]     out_cap;

    // unpack the incoming transfer
    assign in_op    = op_t'(s_axis_tuser);
    assign in_value = $signed(s_axis_tdata[31:0]);
    assign in_pos   = s_axis_tdata[39:32];

    pair_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pair_dp #(
        .STORE_DEPTH    (STORE_DEPTH),
        .START_CAPACITY (START_CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (in_op),
        .in_value   (in_value),
        .in_pos     (in_pos),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (out_status),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_cap    (out_cap)
    );

    // pack the result transfer
    assign m_axis_tdata = {6'b0, out_cap, out_count, $unsigned(out_data)};
    assign m_axis_tuser = out_status;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packed_array_insert_remove_top. Items are sent on
// the input stream and mirrored into a local model of the packed list, its
// count and its nominal capacity. Each output transfer is checked field by
// field against the oldest predicted result, under random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pair_pkg::*;

    localparam int DEPTH       = 256;
    localparam int START_CAP   = 4;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 400;
    // Worst item is a full-depth search or shift.
    localparam int DRAIN_WAIT  = 2 * DEPTH + 100;
    localparam int CYCLE_LIMIT = 4_000_000;

    // One predicted output transfer.
    typedef struct packed {
        status_t     status;
        logic [31:0] read_data;
        logic [8:0]  entry_count;
        logic [8:0]  capacity;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // value[31:0], position[39:32], zero pad
    logic [1:0]  s_axis_tuser = '0;     // operation[1:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // read_data[31:0], entry_count[40:32],
                                        // nominal_capacity[49:41], zero pad
    logic [1:0]  m_axis_tuser;          // status[1:0]

    // Shared test controls; written with nonblocking assignments only.
    logic        idle_en = 1'b1;        // random idling on both sides
    logic        hold_on = 1'b0;        // receiver held off
    event        hold_go;

    // Local copy of the list state.
    logic [31:0] model_mem [DEPTH];
    int          model_count = 0;
    int          model_cap   = START_CAP;

    list_result_t pending_q[$];         // predicted results, oldest first
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    packed_array_insert_remove_top #(
        .STORE_DEPTH    (DEPTH),
        .START_CAPACITY (START_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------

    // Shift-delete: later entries move down one place, then shrink check.
    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < model_count; i++)
            model_mem[i] = model_mem[i + 1];
        model_count--;
        if (model_count < model_cap / 4)
            model_cap = model_cap / 2;
    endfunction

    function automatic list_result_t apply_list_op(input op_t op,
                                                   input logic [31:0] val,
                                                   input logic [7:0] pos);
        list_result_t r;
        int           hit;
        int           i;
        r.status    = ST_DONE;
        r.read_data = '0;
        hit         = -1;
        case (op)
            OP_APPEND:
            begin
                if (model_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // growth is clipped at the store depth
                    if (model_count >= model_cap)
                        model_cap = (model_cap * 2 > DEPTH) ? DEPTH : model_cap * 2;
                    model_mem[model_count] = val;
                    model_count++;
                end
            end
            OP_REMOVE_VAL:
            begin
                for (i = 0; i < model_count && hit < 0; i++)
                    if (model_mem[i] == val)
                        hit = i;
                if (hit >= 0)
                    drop_entry(hit);
                else
                    r.status = ST_MISS;
            end
            OP_REMOVE_AT:
            begin
                if (int'(pos) < model_count)
                    drop_entry(int'(pos));
                else
                    r.status = ST_MISS;
            end
            default:
            begin
                if (int'(pos) < model_count)
                    r.read_data = model_mem[pos];
                else
                    r.status = ST_MISS;
            end
        endcase
        r.entry_count = model_count[8:0];
        r.capacity    = model_cap[8:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one item per call, prediction taken at the accepting edge.
    // Valid is only lowered when a gap is inserted, so back-to-back items
    // never see a low/high pair in one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input op_t op, input logic [31:0] val,
                             input logic [7:0] pos);
        if (idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {8'h00, pos, val};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_q.push_back(apply_list_op(op, val, pos));
    endtask

    // Mostly values already in the list (hits and duplicates), some fresh
    // random words, some corner words.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (model_count > 0 && r < 60)
            return model_mem[$urandom_range(0, model_count - 1)];
        else if (r < 70)
            return 32'(signed'($urandom_range(0, 6)) - 3);
        else if (r < 74)
            return (r[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom();
    endfunction

    // Mostly a valid index, otherwise anything the field allows.
    function automatic logic [7:0] pick_position();
        if (model_count > 0 && $urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, model_count - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random ready, forced low during a hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_on &&
                             (!idle_en || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // Long hold-off, counted here while the sender keeps offering items.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
                 $time, field, got, want);
        mismatch_count++;
    endtask

    // Output check against the oldest prediction.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
            else
            begin
                want = pending_q.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] != want.read_data)
                    report_mismatch("read_data", m_axis_tdata[31:0], want.read_data);
                if (m_axis_tdata[40:32] != want.entry_count)
                    report_mismatch("entry_count", 32'(m_axis_tdata[40:32]),
                                    32'(want.entry_count));
                if (m_axis_tdata[49:41] != want.capacity)
                    report_mismatch("nominal_capacity", 32'(m_axis_tdata[49:41]),
                                    32'(want.capacity));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty-list misses, word extremes, growth, first-match removal,
    // out-of-range indexes and shrink down to the floor of two.
    task automatic test_directed();
        send_item(OP_READ,       32'h0,         8'd0);    // read on empty
        send_item(OP_REMOVE_AT,  32'h0,         8'd0);    // remove on empty
        send_item(OP_REMOVE_VAL, 32'h0,         8'd0);    // search on empty
        send_item(OP_APPEND,     32'h8000_0000, 8'hff);
        send_item(OP_APPEND,     32'h7fff_ffff, 8'h00);
        send_item(OP_APPEND,     32'hffff_ffff, 8'h00);
        send_item(OP_APPEND,     32'h0000_0000, 8'h00);
        send_item(OP_APPEND,     32'hffff_ffff, 8'h00);   // at capacity: grows to 8
        send_item(OP_READ,       32'hffff_ffff, 8'd0);
        send_item(OP_READ,       32'h0,         8'd4);
        send_item(OP_READ,       32'h0,         8'd5);    // one past the end
        send_item(OP_READ,       32'h0,         8'd255);
        send_item(OP_REMOVE_VAL, 32'hffff_ffff, 8'd0);    // first of two copies
        send_item(OP_READ,       32'h0,         8'd2);
        send_item(OP_REMOVE_VAL, 32'h1234_5678, 8'd0);    // not present
        send_item(OP_REMOVE_AT,  32'h0,         8'd4);    // index at count
        send_item(OP_REMOVE_AT,  32'h0,         8'd3);    // last entry
        send_item(OP_REMOVE_AT,  32'h0,         8'd0);    // first: 2 not below 8/4
        send_item(OP_REMOVE_AT,  32'h0,         8'd0);    // 1 < 8/4, halves to 4
        send_item(OP_REMOVE_VAL, 32'h0000_0000, 8'd0);    // down to empty, cap 2
        send_item(OP_APPEND,     32'h5a5a_a5a5, 8'd0);
        send_item(OP_APPEND,     32'ha5a5_5a5a, 8'd0);
        send_item(OP_APPEND,     32'h0000_0001, 8'd0);    // grows from 2 to 4
        send_item(OP_READ,       32'h0,         8'd2);
    endtask

    // Fill to the depth (capacity clips at 256), append to a full store,
    // reach the top index, then drain back down with random removals.
    task automatic test_fill_and_drain();
        while (model_count < DEPTH)
            send_item(OP_APPEND, $urandom(), 8'($urandom_range(0, 255)));
        send_item(OP_APPEND, $urandom(), 8'd0);           // store full
        send_item(OP_READ, 32'h0, 8'd255);
        send_item(OP_REMOVE_VAL, model_mem[DEPTH - 1], 8'd0); // longest search
        send_item(OP_APPEND, $urandom(), 8'd0);
        while (model_count > 0)
        begin
            if ($urandom_range(0, 1))
                send_item(OP_REMOVE_AT, $urandom(), pick_position());
            else
                send_item(OP_REMOVE_VAL, pick_value(), 8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver holds off while the sender keeps going, so the result
    // register and the work slot fill and the input side stalls.
    task automatic test_output_holdoff();
        int n;
        -> hold_go;
        for (n = 0; n < 24; n++)
            send_item((n % 3 == 2) ? OP_READ : OP_APPEND, $urandom(), pick_position());
    endtask

    // Random mix. The append share depends on the count so the list rises
    // and falls; a middle stretch runs with no idling on either side.
    task automatic test_random_mix(input int n_items);
        int n;
        int r;
        int append_pct;
        for (n = 0; n < n_items; n++)
        begin
            if (n == n_items / 3)
                idle_en <= 1'b0;
            if (n == n_items / 2)
                idle_en <= 1'b1;
            append_pct = (model_count < 8) ? 55 : (model_count > 60) ? 15 : 35;
            r = $urandom_range(0, 99);
            if (r < append_pct)
                send_item(OP_APPEND, pick_value(), 8'($urandom_range(0, 255)));
            else if (r < append_pct + 20)
                send_item(OP_REMOVE_VAL, pick_value(), 8'($urandom_range(0, 255)));
            else if (r < append_pct + 40)
                send_item(OP_REMOVE_AT, $urandom(), pick_position());
            else
                send_item(OP_READ, $urandom(), pick_position());
        end
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_output_holdoff();
        test_random_mix(510);

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        // catch any stray transfer after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
